// File: rtl/core/ptld_pkg.sv
// ----------------------------------------------------------------------------
// ptld_pkg
// Shared types and constants of the point-to-line distance pipeline.
// ----------------------------------------------------------------------------
package ptld_pkg;

  localparam int unsigned DistW     = 17;
  localparam int unsigned SatShift  = 34;
  localparam int unsigned RootSteps = SatShift / 2;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // travels alongside the data from stage 7 through the divider and root stages
  typedef struct packed {
    logic vld;
    logic degen;
    logic sat;
  } ptld_tag_t;

endpackage

// File: rtl/core/ptld_div.sv
// ----------------------------------------------------------------------------
// ptld_div
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow check ahead of it.
// ----------------------------------------------------------------------------
module ptld_div #(
  parameter int unsigned NumW = 70,
  parameter int unsigned DenW = 34
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  ptld_pkg::ptld_tag_t           tag_i,
  input  logic [NumW-1:0]               num_i,
  input  logic [DenW-1:0]               den_i,
  output ptld_pkg::ptld_tag_t           tag_o,
  output logic [ptld_pkg::SatShift-1:0] quo_o
);
  import ptld_pkg::*;

  localparam int unsigned RemW = (NumW > DenW + SatShift) ? NumW : DenW + SatShift;

  ptld_tag_t                 tag_q [SatShift+1];
  logic [RemW-1:0]           rem_q [SatShift+1];
  logic [DenW-1:0]           den_q [SatShift+1];
  logic [SatShift-1:0]       quo_q [SatShift+1];

  logic [RemW-1:0] num_ext, den_sat;
  logic            sat_d;

  assign num_ext = RemW'(num_i);
  assign den_sat = RemW'(den_i) << SatShift;
  assign sat_d   = num_ext >= den_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else if (en_i) begin
      tag_q[0] <= '{vld: tag_i.vld, degen: tag_i.degen, sat: sat_d};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_ext;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < SatShift; i++) begin : g_stage
    localparam int unsigned K = SatShift - 1 - i;
    logic [RemW-1:0] trial;
    logic            ge;
    assign trial = RemW'(den_q[i]) << K;
    assign ge    = rem_q[i] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[i+1] <= '0;
      end else if (en_i) begin
        tag_q[i+1] <= tag_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge ? rem_q[i] - trial : rem_q[i];
        den_q[i+1] <= den_q[i];
        quo_q[i+1] <= quo_q[i] | (SatShift'(ge) << K);
      end
    end
  end

  assign tag_o = tag_q[SatShift];
  assign quo_o = quo_q[SatShift];

endmodule

// File: rtl/core/ptld_isqrt.sv
// ----------------------------------------------------------------------------
// ptld_isqrt
// Pipelined integer square root, one result bit per stage; the last stage
// is the output register and applies saturation.
// ----------------------------------------------------------------------------
module ptld_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  ptld_pkg::ptld_tag_t           tag_i,
  input  logic [ptld_pkg::SatShift-1:0] rad_i,
  output ptld_pkg::ptld_tag_t           tag_o,
  output logic [ptld_pkg::DistW-1:0]    root_o
);
  import ptld_pkg::*;

  localparam int unsigned RemW = SatShift + 2;

  ptld_tag_t        tag_q [RootSteps+1];
  logic [RemW-1:0]  rem_q [RootSteps+1];
  logic [DistW-1:0] res_q [RootSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RemW'(rad_i);
      res_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < RootSteps; i++) begin : g_stage
    localparam int unsigned J = RootSteps - 1 - i;
    logic [RemW-1:0]  trial;
    logic             ge;
    logic [DistW-1:0] res_d;
    // (res + 2^J)^2 - res^2
    assign trial = (RemW'(res_q[i]) << (J + 1)) + (RemW'(1) << (2 * J));
    assign ge    = rem_q[i] >= trial;
    assign res_d = res_q[i] | (DistW'(ge) << J);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[i+1] <= '0;
      end else if (en_i) begin
        tag_q[i+1] <= tag_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge ? rem_q[i] - trial : rem_q[i];
        if (i == RootSteps - 1) begin
          res_q[i+1] <= tag_q[i].sat ? DistMax : res_d;
        end else begin
          res_q[i+1] <= res_d;
        end
      end
    end
  end

  assign tag_o  = tag_q[RootSteps];
  assign root_o = res_q[RootSteps];

endmodule

// File: rtl/core/point_to_line_distance_3d.sv
// ----------------------------------------------------------------------------
// point_to_line_distance_3d
// Perpendicular distance from a point to the line through a and b; Q8.8 coordinates, unsigned Q9.8 distance.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid_i/in_ready_o, point_*, line_a/b_* | in
//  out     | out_valid_o/out_ready_i, dist_res, degen   | out
//
// One beat per cycle while the output is not held. 7 front stages (subtract,
// products, cross, magnitude, partial products, squares, sum), 35 divider
// stages and 18 root stages (input register and 17 steps). The pipeline stalls
// as a whole while the output beat waits; reset clears only valid and tag bits.
// ----------------------------------------------------------------------------
module point_to_line_distance_3d #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]    point_x_i,
  input  logic signed [COORD_WIDTH-1:0]    point_y_i,
  input  logic signed [COORD_WIDTH-1:0]    point_z_i,
  input  logic signed [COORD_WIDTH-1:0]    line_a_x_i,
  input  logic signed [COORD_WIDTH-1:0]    line_a_y_i,
  input  logic signed [COORD_WIDTH-1:0]    line_a_z_i,
  input  logic signed [COORD_WIDTH-1:0]    line_b_x_i,
  input  logic signed [COORD_WIDTH-1:0]    line_b_y_i,
  input  logic signed [COORD_WIDTH-1:0]    line_b_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ptld_pkg::DistW-1:0]       dist_res_o,
  output logic                             degenerate_o
);
  import ptld_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned H    = W + 1;       // difference width
  localparam int unsigned CW   = 2 * H + 1;   // cross component
  localparam int unsigned MW   = 2 * H;       // its magnitude / squares of diffs
  localparam int unsigned SQW  = 4 * H;
  localparam int unsigned NumW = SQW + 2;

  logic en;
  ptld_tag_t div_tag, out_tag;
  logic [SatShift-1:0] quo;

  assign out_valid_o  = out_tag.vld;
  assign en           = !out_tag.vld || out_ready_i;
  assign in_ready_o   = en;
  assign degenerate_o = out_tag.degen;

  // stage 1: differences
  logic            v1_vld_q, degen1_q;
  logic signed [H-1:0] v1_q [3];
  logic signed [H-1:0] v2_q [3];
  logic signed [H-1:0] v1_d [3];
  logic signed [H-1:0] v2_d [3];

  assign v1_d[0] = H'(line_b_x_i) - H'(line_a_x_i);
  assign v1_d[1] = H'(line_b_y_i) - H'(line_a_y_i);
  assign v1_d[2] = H'(line_b_z_i) - H'(line_a_z_i);
  assign v2_d[0] = H'(point_x_i) - H'(line_a_x_i);
  assign v2_d[1] = H'(point_y_i) - H'(line_a_y_i);
  assign v2_d[2] = H'(point_z_i) - H'(line_a_z_i);

  // stage 2: products
  logic                 s2_vld_q, degen2_q;
  logic signed [MW-1:0] pc_q [6];
  logic signed [MW-1:0] sq1_q [3];
  logic signed [MW-1:0] sq2_q [3];

  // stage 3: cross components and plain sums
  logic                 s3_vld_q, degen3_q;
  logic signed [CW-1:0] c_q [3];
  logic [MW-1:0]        den3_q, n23_q;

  // stage 4: magnitudes
  logic          s4_vld_q, degen4_q;
  logic [MW-1:0] mag_q [3];
  logic [MW-1:0] den4_q, n24_q;

  // stage 5: partial products of the squares
  logic          s5_vld_q, degen5_q;
  logic [MW-1:0] hh_q [3];
  logic [MW-1:0] hl_q [3];
  logic [MW-1:0] ll_q [3];
  logic [MW-1:0] den5_q, n25_q;

  // stage 6: squares
  logic           s6_vld_q, degen6_q;
  logic [SQW-1:0] sq_q [3];
  logic [MW-1:0]  den6_q, n26_q;

  // stage 7: numerator and denominator
  ptld_tag_t       s7_tag_q;
  logic [NumW-1:0] num7_q;
  logic [MW-1:0]   den7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_tag_q <= '0;
    end else if (en) begin
      v1_vld_q <= in_valid_i;
      s2_vld_q <= v1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_tag_q <= '{vld: s6_vld_q, degen: degen6_q, sat: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v1_q[i] <= v1_d[i];
        v2_q[i] <= v2_d[i];
      end
      degen1_q <= (v1_d[0] == '0) && (v1_d[1] == '0) && (v1_d[2] == '0);

      pc_q[0] <= MW'(v1_q[1]) * MW'(v2_q[2]);
      pc_q[1] <= MW'(v1_q[2]) * MW'(v2_q[1]);
      pc_q[2] <= MW'(v1_q[2]) * MW'(v2_q[0]);
      pc_q[3] <= MW'(v1_q[0]) * MW'(v2_q[2]);
      pc_q[4] <= MW'(v1_q[0]) * MW'(v2_q[1]);
      pc_q[5] <= MW'(v1_q[1]) * MW'(v2_q[0]);
      for (int i = 0; i < 3; i++) begin
        sq1_q[i] <= MW'(v1_q[i]) * MW'(v1_q[i]);
        sq2_q[i] <= MW'(v2_q[i]) * MW'(v2_q[i]);
      end
      degen2_q <= degen1_q;

      for (int i = 0; i < 3; i++) begin
        c_q[i] <= CW'(pc_q[2*i]) - CW'(pc_q[2*i+1]);
      end
      den3_q   <= MW'(sq1_q[0]) + MW'(sq1_q[1]) + MW'(sq1_q[2]);
      n23_q    <= MW'(sq2_q[0]) + MW'(sq2_q[1]) + MW'(sq2_q[2]);
      degen3_q <= degen2_q;

      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= c_q[i][CW-1] ? MW'(-c_q[i]) : MW'(c_q[i]);
      end
      den4_q   <= den3_q;
      n24_q    <= n23_q;
      degen4_q <= degen3_q;

      // magnitude split into H-bit halves
      for (int i = 0; i < 3; i++) begin
        hh_q[i] <= MW'(mag_q[i][MW-1:H]) * MW'(mag_q[i][MW-1:H]);
        hl_q[i] <= MW'(mag_q[i][MW-1:H]) * MW'(mag_q[i][H-1:0]);
        ll_q[i] <= MW'(mag_q[i][H-1:0]) * MW'(mag_q[i][H-1:0]);
      end
      den5_q   <= den4_q;
      n25_q    <= n24_q;
      degen5_q <= degen4_q;

      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (SQW'(hh_q[i]) << (2 * H)) + (SQW'(hl_q[i]) << (H + 1))
                 + SQW'(ll_q[i]);
      end
      den6_q   <= den5_q;
      n26_q    <= n25_q;
      degen6_q <= degen5_q;

      if (degen6_q) begin
        num7_q <= NumW'(n26_q);
        den7_q <= MW'(1);
      end else begin
        num7_q <= NumW'(sq_q[0]) + NumW'(sq_q[1]) + NumW'(sq_q[2]);
        den7_q <= den6_q;
      end
    end
  end

  ptld_div #(
    .NumW (NumW),
    .DenW (MW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (s7_tag_q),
    .num_i  (num7_q),
    .den_i  (den7_q),
    .tag_o  (div_tag),
    .quo_o  (quo)
  );

  ptld_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (div_tag),
    .rad_i  (quo),
    .tag_o  (out_tag),
    .root_o (dist_res_o)
  );

endmodule

// File: tb/sv/point_to_line_distance_3d_tb.sv
// ----------------------------------------------------------------------------
// point_to_line_distance_3d_tb
// Self-checking bench for the 3D point-to-line distance pipeline. A short
// table of hand-picked queries is followed by random ones (degenerate lines,
// points on the line, full-range and small coordinates). Results are checked
// in order against typed table values or an exact integer predictor; both
// handshakes idle at random, with one long output hold-off and one full drain.
// ----------------------------------------------------------------------------
module point_to_line_distance_3d_tb;

  import ptld_pkg::*;

  localparam int unsigned CW      = 16;
  localparam int unsigned NRand   = 630;
  localparam int unsigned Latency = 60;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t coord_vec_t [9];  // p xyz, a xyz, b xyz

  typedef struct {
    logic [DistW-1:0] dist_val;
    logic             degen;
  } dist_beat_t;

  typedef struct {
    coord_vec_t       c;
    bit               typed;
    logic [DistW-1:0] dist_val;
    logic             degen;
  } query_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  coord_t px, py, pz, ax, ay, az, bx, by, bz;
  logic [DistW-1:0] dist_res_o;
  logic degenerate_o;

  dist_beat_t dist_q[$];
  query_row_t query_tab[14];
  int unsigned n_sent, n_seen, n_degen, n_err;
  int unsigned burst_left;

  point_to_line_distance_3d #(.COORD_WIDTH(CW)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .point_x_i(px), .point_y_i(py), .point_z_i(pz),
    .line_a_x_i(ax), .line_a_y_i(ay), .line_a_z_i(az),
    .line_b_x_i(bx), .line_b_y_i(by), .line_b_z_i(bz),
    .out_valid_o, .out_ready_i, .dist_res_o, .degenerate_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("timeout at %0t, %0d beats still outstanding", $time, dist_q.size());
    $display("point_to_line_distance_3d_tb: FAIL");
    $finish;
  end

  function automatic logic [DistW-1:0] isqrt34(logic [33:0] q);
    logic [DistW-1:0] r, t;
    r = '0;
    for (int b = DistW - 1; b >= 0; b--) begin
      t = r | (DistW'(1) << b);
      if (64'(t) * 64'(t) <= 64'(q)) r = t;
    end
    return r;
  endfunction

  // floor(sqrt(floor(|v1 x v2|^2 / |v1|^2))), or |p - a| for a degenerate line
  function automatic dist_beat_t predict_dist(coord_vec_t c);
    dist_beat_t       res;
    longint           v1[3], v2[3], cr[3];
    logic signed [127:0] num, den, t, q;
    for (int i = 0; i < 3; i++) begin
      v1[i] = longint'(c[6+i]) - longint'(c[3+i]);
      v2[i] = longint'(c[i]) - longint'(c[3+i]);
    end
    res.degen = (v1[0] == 0) && (v1[1] == 0) && (v1[2] == 0);
    num = '0;
    den = '0;
    if (res.degen) begin
      for (int i = 0; i < 3; i++) num += 128'(v2[i] * v2[i]);
      den = 128'sd1;
    end else begin
      cr[0] = v1[1] * v2[2] - v1[2] * v2[1];
      cr[1] = v1[2] * v2[0] - v1[0] * v2[2];
      cr[2] = v1[0] * v2[1] - v1[1] * v2[0];
      for (int i = 0; i < 3; i++) begin
        t = cr[i];
        num += t * t;
        den += 128'(v1[i] * v1[i]);
      end
    end
    q = num / den;
    if (q >= (128'sd1 <<< SatShift)) res.dist_val = DistMax;
    else res.dist_val = isqrt34(q[33:0]);
    return res;
  endfunction

  function automatic query_row_t mk_row(int c0, int c1, int c2, int c3, int c4,
                                        int c5, int c6, int c7, int c8,
                                        bit typed, int dist_val, bit degen);
    query_row_t r;
    r.c = '{coord_t'(c0), coord_t'(c1), coord_t'(c2), coord_t'(c3), coord_t'(c4),
            coord_t'(c5), coord_t'(c6), coord_t'(c7), coord_t'(c8)};
    r.typed    = typed;
    r.dist_val = DistW'(dist_val);
    r.degen    = degen;
    return r;
  endfunction

  // called just after a rising edge; returns just after the accepting edge or after a random idle gap
  task automatic send_query(query_row_t r);
    in_valid_i <= 1'b1;
    {px, py, pz} <= {r.c[0], r.c[1], r.c[2]};
    {ax, ay, az} <= {r.c[3], r.c[4], r.c[5]};
    {bx, by, bz} <= {r.c[6], r.c[7], r.c[8]};
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
      @(posedge clk_i);
    end
    if (r.typed) dist_q.push_back('{r.dist_val, r.degen});
    else dist_q.push_back(predict_dist(r.c));
    n_sent++;
    @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  function automatic coord_t rnd_coord(int unsigned span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  function automatic query_row_t rnd_query();
    query_row_t r;
    int unsigned kind, span;
    int k;
    kind = $urandom_range(0, 9);
    span = ($urandom_range(0, 2) == 0) ? 0 : (1 << $urandom_range(2, 13));
    foreach (r.c[i]) r.c[i] = rnd_coord(span);
    r.typed = 1'b0;
    case (kind)
      0, 1: for (int i = 0; i < 3; i++) r.c[6+i] = r.c[3+i];   // a equals b
      2: begin                                                  // p on the line
        span = 1 << $urandom_range(2, 10);
        k = int'($urandom_range(0, 6)) - 3;
        for (int i = 0; i < 3; i++) begin
          r.c[3+i] = rnd_coord(span);
          r.c[6+i] = rnd_coord(span);
          r.c[i]   = coord_t'(r.c[3+i] + k * (r.c[6+i] - r.c[3+i]));
        end
      end
      3: foreach (r.c[i]) r.c[i] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: ;
    endcase
    return r;
  endfunction

  // stimulus
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    {px, py, pz, ax, ay, az, bx, by, bz} = '0;
    n_sent = 0;
    burst_left = 4;
    query_tab[0]  = mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1);
    query_tab[1]  = mk_row(256, 0, 0, 0, 0, 0, 0, 0, 0, 1, 256, 1);
    query_tab[2]  = mk_row(0, 256, 0, 0, 0, 0, 256, 0, 0, 1, 256, 0);
    query_tab[3]  = mk_row(512, 0, 0, 0, 0, 0, 256, 0, 0, 1, 0, 0);
    query_tab[4]  = mk_row(0, 0, -768, 100, 0, 0, 100, 5, 0, 1, 774, 0);
    query_tab[5]  = mk_row(-300, 0, 0, 0, 0, 0, 0, 0, 1, 1, 300, 0);
    query_tab[6]  = mk_row(-32768, -32768, -32768, 32767, 32767, 32767,
                           32767, 32767, 32767, 0, 0, 0);
    query_tab[7]  = mk_row(32767, -32768, 32767, -32768, -32768, -32768,
                           32767, 32767, 32767, 0, 0, 0);
    query_tab[8]  = mk_row(32767, 32767, 32767, -32768, -32768, -32768,
                           -32767, -32768, -32768, 0, 0, 0);
    query_tab[9]  = mk_row(-32768, 32767, -32768, 32767, -32768, 32767,
                           -32768, -32768, 32767, 0, 0, 0);
    query_tab[10] = mk_row(-1, -1, -1, 0, 0, 0, 1, 1, 1, 1, 0, 0);
    query_tab[11] = mk_row(32767, 32767, 32767, 32767, 32767, 32767,
                           32767, 32767, 32767, 1, 0, 1);
    query_tab[12] = mk_row(3, 4, 0, 0, 0, 7, 0, 0, -9, 1, 5, 0);
    query_tab[13] = mk_row(1, 2, 3, -5, 7, 11, 13, -17, 19, 0, 0, 0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (query_tab[i]) send_query(query_tab[i]);
    for (int n = 0; n < NRand; n++) begin
      if (n == NRand / 2) begin
        // let the pipeline run dry once
        in_valid_i <= 1'b0;
        wait (dist_q.size() == 0);
        @(posedge clk_i);
      end
      send_query(rnd_query());
    end
    in_valid_i <= 1'b0;
    wait (dist_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    $display("%0d queries sent, %0d results checked (%0d degenerate lines)",
             n_sent, n_seen, n_degen);
    $display("covered extremes, points on the line, an output hold-off and a full drain");
    if (n_err == 0) $display("point_to_line_distance_3d_tb: PASS");
    else $display("point_to_line_distance_3d_tb: FAIL");
    $finish;
  end

  // receiver: stalls in phases of varying density, plus one long hold-off
  initial begin
    int unsigned phase_left, busy_pct;
    bit held;
    out_ready_i = 1'b0;
    held = 1'b0;
    phase_left = 0;
    busy_pct = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && n_sent >= 40) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(5, 60);
        case ($urandom_range(0, 2))
          0: busy_pct = 0;
          1: busy_pct = 30;
          default: busy_pct = 70;
        endcase
      end
      phase_left--;
      out_ready_i <= ($urandom_range(0, 99) >= busy_pct);
    end
  end

  // result checker
  initial begin
    dist_beat_t exp_beat;
    n_seen = 0;
    n_degen = 0;
    n_err = 0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        n_seen++;
        if (dist_q.size() == 0) begin
          n_err++;
          $display("%0t: result beat with nothing expected (dist %0d degen %0b)",
                   $time, dist_res_o, degenerate_o);
        end else begin
          exp_beat = dist_q.pop_front();
          if (exp_beat.degen) n_degen++;
          if (dist_res_o !== exp_beat.dist_val) begin
            n_err++;
            $display("%0t: dist_res expected %0d, got %0d",
                     $time, exp_beat.dist_val, dist_res_o);
          end
          if (degenerate_o !== exp_beat.degen) begin
            n_err++;
            $display("%0t: degenerate expected %0b, got %0b",
                     $time, exp_beat.degen, degenerate_o);
          end
        end
      end
    end
  end

endmodule

// File: files.f
rtl/core/ptld_pkg.sv
rtl/core/ptld_div.sv
rtl/core/ptld_isqrt.sv
rtl/core/point_to_line_distance_3d.sv
tb/sv/point_to_line_distance_3d_tb.sv
